// File: rtl/bpfa_pkg.sv
`timescale 1ns / 1ps

package bpfa_pkg;

	// Field widths of the request and response beats
	localparam int START_W = 16;
	localparam int COUNT_W = 17;
	localparam int INDEX_W = 16;

	// Command codes
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_LOCK  = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OOM     = 2'd1;
	localparam logic [1:0] ST_CLIPPED = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [START_W-1:0] start_page;
		logic [COUNT_W-1:0] page_count;
	} req_t;

	typedef struct packed {
		logic [INDEX_W-1:0] page_index;
		logic [1:0]         status;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic clr_wr;
		logic load;
		logic mul;
		logic base;
		logic hint_lower;
		logic full_wr;
		logic rd_issue;
		logic rmw_wr;
		logic advance;
		logic alloc_load;
		logic alloc_rd;
		logic skip;
		logic take;
		logic oom;
		logic rsp_load;
	} bpfa_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic empty;
		logic mask_full;
		logic last_word;
		logic scan_end;
		logic word_full;
	} bpfa_stat_t;

endpackage

// File: rtl/bpfa_ctrl.sv
`timescale 1ns / 1ps

module bpfa_ctrl import bpfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_cmd,
	output logic       req_stall,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output bpfa_cmd_t  cmd,
	input  bpfa_stat_t st
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_R_MUL,
		S_R_BASE,
		S_R_CHECK,
		S_R_WORD,
		S_R_RMW,
		S_A_LOAD,
		S_A_READ,
		S_A_CHECK,
		S_RESP
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Decode datapath commands from the current state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR:   cmd.clr_wr = 1'b1;
			S_IDLE:    cmd.load = req_valid;
			S_R_MUL:   cmd.mul = 1'b1;
			S_R_BASE:  cmd.base = 1'b1;
			S_R_CHECK: cmd.hint_lower = !st.empty;
			S_R_WORD: begin
				cmd.full_wr  = st.mask_full;
				cmd.advance  = st.mask_full;
				cmd.rd_issue = !st.mask_full;
			end
			S_R_RMW: begin
				cmd.rmw_wr  = 1'b1;
				cmd.advance = 1'b1;
			end
			S_A_LOAD:  cmd.alloc_load = 1'b1;
			S_A_READ: begin
				cmd.oom      = st.scan_end;
				cmd.alloc_rd = !st.scan_end;
			end
			S_A_CHECK: begin
				cmd.skip = st.word_full;
				cmd.take = !st.word_full;
			end
			S_RESP:    cmd.rsp_load = rsp_free;
			default:   cmd = '0;
		endcase
	end

	// Hold state and the response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (st.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						case (req_cmd)
							CMD_ALLOC:          state_q <= S_A_LOAD;
							CMD_LOCK, CMD_FREE: state_q <= S_R_MUL;
							default:            state_q <= S_RESP;
						endcase
					end
				end
				S_R_MUL:   state_q <= S_R_BASE;
				S_R_BASE:  state_q <= S_R_CHECK;
				S_R_CHECK: state_q <= st.empty ? S_RESP : S_R_WORD;
				S_R_WORD: begin
					if (!st.mask_full) begin
						state_q <= S_R_RMW;
					end else if (st.last_word) begin
						state_q <= S_RESP;
					end
				end
				S_R_RMW:   state_q <= st.last_word ? S_RESP : S_R_WORD;
				S_A_LOAD:  state_q <= S_A_READ;
				S_A_READ:  state_q <= st.scan_end ? S_RESP : S_A_CHECK;
				S_A_CHECK: state_q <= st.word_full ? S_A_READ : S_RESP;
				S_RESP: begin
					if (rsp_free) state_q <= S_IDLE;
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	a_resp_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && rsp_free) |=> (state_q == S_IDLE && rsp_valid_q))
		else $error("response not presented after leaving RESP");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RESP))
		else $error("response valid rose outside RESP");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |=> (state_q != S_CLEAR))
		else $error("clearing pass restarted");

endmodule

// File: rtl/bpfa_dpath.sv
`timescale 1ns / 1ps

module bpfa_dpath import bpfa_pkg::*; #(
	parameter int NUM_PAGES = 65536,
	parameter int WORD_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	input  bpfa_cmd_t  cmd,
	output bpfa_stat_t st,
	output rsp_t       rsp
);

	localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int HW = $clog2(MAP_WORDS + 1);
	localparam int EW = $clog2(NUM_PAGES + 2 * WORD_BITS + 2 ** (COUNT_W + 1));
	localparam int BW = $clog2(WORD_BITS + 1);
	localparam int ZW = $clog2(WORD_BITS);
	// start / WORD_BITS by reciprocal; exact for START_W-bit numerators
	localparam int RECIP_SHIFT = START_W + 7;
	localparam int RECIP = (2 ** RECIP_SHIFT + WORD_BITS - 1) / WORD_BITS;
	localparam int RW = $clog2(RECIP + 1);
	localparam int PRW = START_W + RW;
	localparam int QW = PRW - RECIP_SHIFT;

	logic [WORD_BITS-1:0] page_used_q [MAP_WORDS];
	logic [WORD_BITS-1:0] rd_q;
	logic [HW-1:0]        cur_w_q;
	logic [HW-1:0]        hint_q;
	logic [EW-1:0]        cur_base_q;
	logic [EW-1:0]        hint_base_q;
	logic [EW-1:0]        start_q;
	logic [EW-1:0]        end_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 used_q;
	logic                 empty_q;
	logic [PRW-1:0]       prod_q;
	rsp_t                 res_q;
	rsp_t                 rsp_q;

	logic [EW-1:0]        end_raw;
	logic                 clipped;
	logic [EW-1:0]        end_clip;
	logic [EW-1:0]        top;
	logic [EW-1:0]        lo_page;
	logic [EW-1:0]        hi_page;
	logic [BW-1:0]        lo_off;
	logic [BW-1:0]        hi_off;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] full_val;
	logic [WORD_BITS-1:0] merged;
	logic [WORD_BITS-1:0] set_val;
	logic [WORD_BITS-1:0] wdata;
	logic [ZW-1:0]        zb;
	logic [QW-1:0]        ws;
	logic [AW-1:0]        addr;
	logic                 we;

	// Clip the range at the end of the map
	assign end_raw  = start_q + EW'(count_q);
	assign clipped  = end_raw > EW'(NUM_PAGES);
	assign end_clip = clipped ? EW'(NUM_PAGES) : end_raw;

	// Bounds of the range inside the current word
	assign top     = cur_base_q + EW'(WORD_BITS);
	assign lo_page = (start_q > cur_base_q) ? start_q : cur_base_q;
	assign hi_page = (end_q < top) ? end_q : top;
	assign lo_off  = BW'(lo_page - cur_base_q);
	assign hi_off  = BW'(hi_page - cur_base_q);

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			mask[b] = (BW'(b) >= lo_off) && (BW'(b) < hi_off);
		end
	end

	assign full_val = used_q ? '1 : '0;
	assign merged   = used_q ? (rd_q | mask) : (rd_q & ~mask);

	// Find the lowest clear bit of the fetched word
	always_comb begin
		zb = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!rd_q[b]) zb = ZW'(b);
		end
	end

	assign set_val = rd_q | (WORD_BITS'(1) << zb);
	assign ws      = prod_q[RECIP_SHIFT +: QW];
	assign addr    = cur_w_q[AW-1:0];

	// Select the write source; all ports share the current word address
	assign we = cmd.clr_wr | cmd.full_wr | cmd.rmw_wr | cmd.take;
	always_comb begin
		if (cmd.clr_wr) begin
			wdata = '1;
		end else if (cmd.full_wr) begin
			wdata = full_val;
		end else if (cmd.rmw_wr) begin
			wdata = merged;
		end else begin
			wdata = set_val;
		end
	end

	// Bitmap memory with registered read
	always_ff @(posedge clk) begin
		if (we) page_used_q[addr] <= wdata;
		if (cmd.rd_issue || cmd.alloc_rd) rd_q <= page_used_q[addr];
	end

	// Word pointer and free-word hint
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_w_q     <= '0;
			cur_base_q  <= '0;
			hint_q      <= HW'(MAP_WORDS);
			hint_base_q <= '0;
		end else begin
			if (cmd.clr_wr) begin
				cur_w_q <= cur_w_q + 1'b1;
			end
			if (cmd.alloc_load) begin
				cur_w_q    <= hint_q;
				cur_base_q <= hint_base_q;
			end
			if (cmd.base) begin
				cur_w_q    <= HW'(ws);
				cur_base_q <= EW'(ws) * EW'(WORD_BITS);
			end
			if (cmd.advance || cmd.skip) begin
				cur_w_q    <= cur_w_q + 1'b1;
				cur_base_q <= top;
			end
			// Words below the hint are all full
			if (cmd.skip) begin
				hint_q      <= cur_w_q + 1'b1;
				hint_base_q <= top;
			end
			if (cmd.hint_lower && !used_q && (cur_w_q < hint_q)) begin
				hint_q      <= cur_w_q;
				hint_base_q <= cur_base_q;
			end
		end
	end

	// Request fields, working result and output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q          <= EW'(req.start_page);
			count_q          <= req.page_count;
			used_q           <= (req.cmd == CMD_LOCK);
			res_q.page_index <= '0;
			res_q.status     <= ST_OK;
		end
		if (cmd.mul) begin
			end_q        <= end_clip;
			empty_q      <= (count_q == '0) || (end_clip <= start_q);
			prod_q       <= PRW'(start_q[START_W-1:0]) * PRW'(RECIP);
			res_q.status <= ((count_q != '0) && clipped) ? ST_CLIPPED : ST_OK;
		end
		if (cmd.oom) begin
			res_q.status <= ST_OOM;
		end
		if (cmd.take) begin
			res_q.page_index <= INDEX_W'(cur_base_q + EW'(zb));
		end
		if (cmd.rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp = rsp_q;

	assign st.clr_last  = (cur_w_q == HW'(MAP_WORDS - 1));
	assign st.empty     = empty_q;
	assign st.mask_full = (lo_off == '0) && (hi_off == BW'(WORD_BITS));
	assign st.last_word = (end_q <= top);
	assign st.scan_end  = (cur_w_q >= HW'(MAP_WORDS));
	assign st.word_full = &rd_q;

	a_hint_range: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= HW'(MAP_WORDS))
		else $error("free-word hint beyond the map");

	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> (!(&rd_q) && (cur_w_q < HW'(MAP_WORDS))))
		else $error("allocation taken from a full or missing word");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.full_wr || cmd.rmw_wr) |-> (cur_w_q < HW'(MAP_WORDS)))
		else $error("range write beyond the map");

endmodule

// File: rtl/bitmap_page_frame_allocator.sv
// Operation: an unused command goes straight to the response beat; allocate scans upward
// from the lowest-free-word hint past full words, answering out of memory at the map end;
// lock/free write whole words directly and partially covered words by read-modify-write
// (on the single bitmap port).
// Throughput: one request at a time; the next is taken while the last response waits.
// Reset: a clearing pass marks every page used by writing each bitmap word, during which
// requests are stalled.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator import bpfa_pkg::*; #(
	parameter int NUM_PAGES = 65536,
	parameter int WORD_BITS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	output logic req_stall,
	output rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_stall
);

	bpfa_cmd_t  cmd;
	bpfa_stat_t st;

	bpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.st        (st)
	);

	bpfa_dpath #(
		.NUM_PAGES (NUM_PAGES),
		.WORD_BITS (WORD_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.st     (st),
		.rsp    (rsp)
	);

endmodule
